>>> src/spq_pkg.sv
package spq_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEFAULT_DEPTH = 16;
    localparam int STATUS_W      = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic ins;
        logic pop;
        logic occ;
    } t_cell_ctl;

endpackage

>>> src/spq_if.sv
interface spq_cmd_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface spq_res_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] popped_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

>>> src/sorted_priority_queue.sv
// Sorted priority queue of signed 32-bit values, smallest first.
// The command channel carries one beat per operation: command 0 inserts value,
// command 1 pops the smallest stored value. Each command beat yields exactly one
// beat on the result channel with popped_value and status (0 done, 1 pop on an
// empty queue, 2 insert on a full queue); popped_value is zero unless a pop
// succeeds. Equal values leave in the order in which they arrived.
// Storage is a row of DEPTH cells; every cell compares its entry with the
// incoming value in the same cycle and shifts towards or away from the head, so
// the whole row is updated together for each command.
// The result beat follows in the cycle after its command beat is taken, and one
// command is taken every cycle while results are taken as they appear.
// Reset empties the queue and drops any pending result.
// When the receiver stalls, the result stays in the output register and no
// further command is taken until that result beat has gone.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_cmd_if.sink   i_cmd,
    spq_res_if.source o_res
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_popped;
    logic [STATUS_W-1:0]       r_status;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_ins;
    logic                      w_pop;
    logic signed [VALUE_W-1:0] w_value [DEPTH];
    logic                      w_gt    [DEPTH];

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_ins       = w_accept && (i_cmd.command == CMD_INSERT) && !w_full;
    assign w_pop       = w_accept && (i_cmd.command == CMD_POP) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_cell_ctl                 w_ctl;
            logic signed [VALUE_W-1:0] w_left_value;
            logic                      w_left_gt;
            logic signed [VALUE_W-1:0] w_right_value;

            assign w_ctl.ins = w_ins;
            assign w_ctl.pop = w_pop;
            assign w_ctl.occ = (CW'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_left_value = '0;
                assign w_left_gt    = 1'b0;
            end else begin : g_mid
                assign w_left_value = w_value[g-1];
                assign w_left_gt    = w_gt[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_right_value = '0;
            end else begin : g_inner
                assign w_right_value = w_value[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_value       (i_cmd.value),
                .i_left_value  (w_left_value),
                .i_left_gt     (w_left_gt),
                .i_right_value (w_right_value),
                .o_value       (w_value[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= w_pop ? w_value[0] : '0;
            if (i_cmd.command == CMD_POP) begin
                r_status <= w_empty ? ST_EMPTY : ST_DONE;
            end else begin
                r_status <= w_full ? ST_FULL : ST_DONE;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.popped_value = r_popped;
    assign o_res.status       = r_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without a command beat");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_res.valid && (o_res.status == ST_DONE))
        else $error("successful pop did not give a done result");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_cmd.command == CMD_INSERT) && w_full
            |=> (o_res.status == ST_FULL) && (r_count == CW'(DEPTH)))
        else $error("insert on a full queue was not rejected");
`endif

endmodule

>>> src/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_left_value,
    input  logic                      i_left_gt,
    input  logic signed [VALUE_W-1:0] i_right_value,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_gt
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // A stored entry greater than the new value makes room for it.
    assign o_gt    = i_ctl.occ && (r_value > i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt || !i_ctl.occ) begin
                n_value = i_value;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> test/sorted_priority_queue_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped;
        logic [STATUS_W-1:0]       status;
    } t_outcome;

    class queue_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        t_outcome                  outcomes[$];
        int                        depth;
        int                        failures;

        function new(int depth_in);
            depth    = depth_in;
            failures = 0;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        // Mirrors the stored list: inserts go in front of the first strictly greater entry.
        function void note_command(logic cmd, logic signed [VALUE_W-1:0] value);
            int       pos;
            t_outcome o;
            o.popped = '0;
            o.status = ST_DONE;
            if (cmd == CMD_INSERT) begin
                if (held.size() >= depth) begin
                    o.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held.size() && !(held[pos] > value)) begin
                        pos++;
                    end
                    held.insert(pos, value);
                end
            end else begin
                if (held.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.popped = held.pop_front();
                end
            end
            outcomes.push_back(o);
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] popped,
                                   logic [STATUS_W-1:0] status);
            t_outcome o;
            if (outcomes.size() == 0) begin
                flag($sformatf("result beat with nothing outstanding: value %0d status %0d",
                               popped, status));
                return;
            end
            o = outcomes.pop_front();
            if (popped !== o.popped) begin
                flag($sformatf("popped_value expected %0d, got %0d", o.popped, popped));
            end
            if (status !== o.status) begin
                flag($sformatf("status expected %0d, got %0d", o.status, status));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    spq_cmd_if cmd_if ();
    spq_res_if res_if ();

    queue_scoreboard sb = new(DEFAULT_DEPTH);

    sorted_priority_queue #(
        .DEPTH(DEFAULT_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(6)) - 32'sd3;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_cmd(logic cmd, logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.value   <= value;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        sb.note_command(cmd, value);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.popped_value, res_if.status);
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int bias;
        logic cmd;
        idle_by_phase  = '{0, 80, 0, 8};
        stall_by_phase = '{0, 0, 80, 8};
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_INSERT;
        cmd_if.value   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A pop on an empty queue, a fill with extremes and duplicates, then an insert when full.
        send_cmd(CMD_POP, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_INSERT, 32'sd1);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_INSERT, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        for (int n = 0; n < DEFAULT_DEPTH - 8; n++) begin
            send_cmd(CMD_INSERT, pick_value());
        end
        send_cmd(CMD_INSERT, 32'sd5);
        repeat (4) send_cmd(CMD_POP, $signed($urandom));

        // Bursts with differing insert bias walk the queue between empty and full.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            bias           = 50;
            for (int n = 0; n < 400; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(3))
                        0: bias = 15;
                        1: bias = 50;
                        2: bias = 80;
                        default: bias = 95;
                    endcase
                end
                cmd = ($urandom_range(99) < bias) ? CMD_INSERT : CMD_POP;
                send_cmd(cmd, pick_value());
            end
        end
        cmd_if.valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
